// ===== src/jfwd_pkg.sv =====
// Shared types, byte codes and decode helpers for the joystick frame to wheel drive block.
package jfwd_pkg;

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_W    = 8'h57;
	localparam logic [7:0] CHAR_P    = 8'h50;
	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_B    = 8'h42;
	localparam logic [7:0] CHAR_C    = 8'h43;
	localparam logic [7:0] CHAR_D    = 8'h44;
	localparam logic [3:0] DIGIT_MASK = 4'hF;
	localparam logic [7:0] AXIS_MAX  = 8'd255;
	localparam logic [7:0] AXIS_MIN  = 8'd0;
	localparam logic [7:0] AXIS_IDLE = 8'd127;

	localparam logic [7:0] RST_CORNER_MAX  = 8'd59;
	localparam logic [7:0] RST_MIDDLE_LOW  = 8'd68;
	localparam logic [7:0] RST_MIDDLE_HIGH = 8'd187;
	localparam logic [7:0] RST_CORNER_MIN  = 8'd196;

	// Motor pin patterns
	localparam logic [7:0] PINS_UP_LEFT    = 8'h3C;
	localparam logic [7:0] PINS_UP         = 8'h7D;
	localparam logic [7:0] PINS_UP_RIGHT   = 8'h41;
	localparam logic [7:0] PINS_RIGHT      = 8'h55;
	localparam logic [7:0] PINS_DOWN_RIGHT = 8'h14;
	localparam logic [7:0] PINS_DOWN       = 8'hD7;
	localparam logic [7:0] PINS_DOWN_LEFT  = 8'hC3;
	localparam logic [7:0] PINS_LEFT       = 8'hFF;
	localparam logic [7:0] PINS_LETTER_A   = 8'h5C;
	localparam logic [7:0] PINS_LETTER_B   = 8'h53;
	localparam logic [7:0] PINS_LETTER_C   = 8'hF1;
	localparam logic [7:0] PINS_LETTER_D   = 8'hF4;
	localparam logic [7:0] PINS_STOP       = 8'h00;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		REG_CORNER_MAX  = 2'd0,
		REG_MIDDLE_LOW  = 2'd1,
		REG_MIDDLE_HIGH = 2'd2,
		REG_CORNER_MIN  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		LET_NONE,
		LET_A,
		LET_B,
		LET_C,
		LET_D
	} letter_t;

	typedef struct packed {
		logic [7:0] corner_max;
		logic [7:0] middle_low;
		logic [7:0] middle_high;
		logic [7:0] corner_min;
	} cfg_t;

	// One classified request passed from front to back
	typedef struct packed {
		logic [7:0] vert;
		logic [7:0] horz;
		letter_t    letter;
		logic       updated;
	} cmd_t;

	function automatic letter_t decode_letter(input logic [7:0] b);
		letter_t l;
		begin
			l = LET_NONE;
			if (b == CHAR_A) l = LET_A;
			else if (b == CHAR_B) l = LET_B;
			else if (b == CHAR_C) l = LET_C;
			else if (b == CHAR_D) l = LET_D;
			return l;
		end
	endfunction

	// Decimal accumulate, saturating at the axis maximum
	function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] b);
		logic [11:0] t;
		begin
			t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, b[3:0] & DIGIT_MASK};
			return (t > {4'd0, AXIS_MAX}) ? AXIS_MAX : t[7:0];
		end
	endfunction

endpackage

// ===== src/jfwd_front.sv =====
// Front end: frame parser that tracks axis state and classifies each received byte.
module jfwd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  logic [7:0]         rx_byte,
	input  logic               q_full,
	output logic               q_push,
	output jfwd_pkg::cmd_t     q_data
);
	import jfwd_pkg::*;

	logic       in_frame_q, second_field_q;
	logic [7:0] vert_acc_q, horz_acc_q, vert_val_q, horz_val_q;

	logic       in_frame_d, second_field_d;
	logic [7:0] vert_acc_d, horz_acc_d, vert_val_d, horz_val_d;
	letter_t    letter;
	logic       updated;
	logic       fire;

	assign rx_ready = !q_full;
	assign fire     = rx_valid && rx_ready;

	always_comb begin
		in_frame_d     = in_frame_q;
		second_field_d = second_field_q;
		vert_acc_d     = vert_acc_q;
		horz_acc_d     = horz_acc_q;
		vert_val_d     = vert_val_q;
		horz_val_d     = horz_val_q;
		letter         = LET_NONE;
		updated        = 1'b0;
		priority if (!in_frame_q) begin
			if (rx_byte == CHAR_W) begin
				in_frame_d     = 1'b1;
				second_field_d = 1'b0;
				vert_acc_d     = AXIS_MIN;
				horz_acc_d     = AXIS_MIN;
			end else begin
				letter = decode_letter(rx_byte);
			end
		end else if (rx_byte == CHAR_CR) begin
			// commit both axes and close the frame
			vert_val_d     = vert_acc_q;
			horz_val_d     = horz_acc_q;
			vert_acc_d     = AXIS_MIN;
			horz_acc_d     = AXIS_MIN;
			in_frame_d     = 1'b0;
			second_field_d = 1'b0;
			updated        = 1'b1;
		end else if (rx_byte == CHAR_P || rx_byte == CHAR_S) begin
			second_field_d = 1'b1;
		end else if (second_field_q) begin
			horz_acc_d = acc_digit(horz_acc_q, rx_byte);
		end else begin
			vert_acc_d = acc_digit(vert_acc_q, rx_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			second_field_q <= 1'b0;
			vert_acc_q     <= AXIS_MIN;
			horz_acc_q     <= AXIS_MIN;
			vert_val_q     <= AXIS_IDLE;
			horz_val_q     <= AXIS_IDLE;
		end else if (fire) begin
			in_frame_q     <= in_frame_d;
			second_field_q <= second_field_d;
			vert_acc_q     <= vert_acc_d;
			horz_acc_q     <= horz_acc_d;
			vert_val_q     <= vert_val_d;
			horz_val_q     <= horz_val_d;
		end
	end

	assign q_push         = fire;
	assign q_data.vert    = vert_val_d;
	assign q_data.horz    = horz_val_d;
	assign q_data.letter  = letter;
	assign q_data.updated = updated;

`ifndef ASSERT_OFF
	a_cr_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && in_frame_q && rx_byte == CHAR_CR) |=> !in_frame_q && !second_field_q)
		else $error("frame not closed by CR");
	a_no_letter_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && in_frame_q) |-> (q_data.letter == LET_NONE))
		else $error("letter classified inside a frame");
`endif

endmodule

// ===== src/jfwd_fifo.sv =====
// Short request queue between the front end and the drive back end.
module jfwd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jfwd_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output jfwd_pkg::cmd_t pop_data
);
	import jfwd_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ===== src/jfwd_back.sv =====
// Back end: zone decode of committed axes, or else the letter code, into motor pins, with the output register.
module jfwd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  jfwd_pkg::cfg_t cfg,
	input  logic           q_not_empty,
	input  jfwd_pkg::cmd_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     motor_pins,
	output logic [7:0]     vertical_axis,
	output logic [7:0]     horizontal_axis,
	output logic           axes_updated
);
	import jfwd_pkg::*;

	logic       out_valid_q;
	logic [7:0] pins_q, vert_q, horz_q;
	logic       upd_q;
	logic [7:0] pins;
	logic       v_lo, v_hi, v_band, h_lo, h_hi, h_band;

	assign v_lo   = q_data.vert <= cfg.corner_max;
	assign v_hi   = q_data.vert >= cfg.corner_min;
	assign v_band = q_data.vert >= cfg.middle_low && q_data.vert <= cfg.middle_high;
	assign h_lo   = q_data.horz <= cfg.corner_max;
	assign h_hi   = q_data.horz >= cfg.corner_min;
	assign h_band = q_data.horz >= cfg.middle_low && q_data.horz <= cfg.middle_high;

	always_comb begin
		priority if (v_lo && h_lo) pins = PINS_UP_LEFT;
		else if (q_data.vert == AXIS_MIN && h_band) pins = PINS_UP;
		else if (v_lo && h_hi) pins = PINS_UP_RIGHT;
		else if (v_band && q_data.horz == AXIS_MAX) pins = PINS_RIGHT;
		else if (v_hi && h_hi) pins = PINS_DOWN_RIGHT;
		else if (q_data.vert == AXIS_MAX && h_band) pins = PINS_DOWN;
		else if (v_hi && h_lo) pins = PINS_DOWN_LEFT;
		else if (v_band && q_data.horz == AXIS_MIN) pins = PINS_LEFT;
		else begin
			unique case (q_data.letter)
				LET_A:    pins = PINS_LETTER_A;
				LET_B:    pins = PINS_LETTER_B;
				LET_C:    pins = PINS_LETTER_C;
				LET_D:    pins = PINS_LETTER_D;
				LET_NONE: pins = PINS_STOP;
				default:  pins = PINS_STOP;
			endcase
		end
	end

	// advance whenever the output register is free or being drained
	assign q_pop = q_not_empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pins_q <= pins;
			vert_q <= q_data.vert;
			horz_q <= q_data.horz;
			upd_q  <= q_data.updated;
		end
	end

	assign out_valid       = out_valid_q;
	assign motor_pins      = pins_q;
	assign vertical_axis   = vert_q;
	assign horizontal_axis = horz_q;
	assign axes_updated    = upd_q;

endmodule

// ===== src/joystick_frame_to_wheel_drive.sv =====
// Top level: configuration registers, front end, request queue and drive back end.
//
//  channel   handshake               payload
//  rx        rx_valid / rx_ready     rx_byte[7:0]
//  out       out_valid / out_ready   motor_pins, vertical_axis, horizontal_axis, axes_updated
//  apb       psel / penable / pready paddr[3:0], pwdata, prdata (32 bit)
//
// One byte per cycle while the queue has room; a taken byte passes through the queue into
// the output register. The front end parses and classifies in the accept cycle, the back
// end decodes zones into the output register. A two-entry queue parts them, so rx_ready
// drops only when the queue is full while out_ready is held low. Reset sets the axes to
// 127, the thresholds to their defaults and empties the queue; no clearing pass is needed.
module joystick_frame_to_wheel_drive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  motor_pins,
	output logic [7:0]  vertical_axis,
	output logic [7:0]  horizontal_axis,
	output logic        axes_updated,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import jfwd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     q_push, q_full, q_pop, q_not_empty;
	cmd_t     push_data, pop_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.corner_max  <= RST_CORNER_MAX;
			cfg_q.middle_low  <= RST_MIDDLE_LOW;
			cfg_q.middle_high <= RST_MIDDLE_HIGH;
			cfg_q.corner_min  <= RST_CORNER_MIN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CORNER_MAX:  cfg_q.corner_max  <= pwdata[7:0];
				REG_MIDDLE_LOW:  cfg_q.middle_low  <= pwdata[7:0];
				REG_MIDDLE_HIGH: cfg_q.middle_high <= pwdata[7:0];
				REG_CORNER_MIN:  cfg_q.corner_min  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CORNER_MAX:  prdata = {24'd0, cfg_q.corner_max};
			REG_MIDDLE_LOW:  prdata = {24'd0, cfg_q.middle_low};
			REG_MIDDLE_HIGH: prdata = {24'd0, cfg_q.middle_high};
			REG_CORNER_MIN:  prdata = {24'd0, cfg_q.corner_min};
			default:         prdata = 32'd0;
		endcase
	end

	jfwd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	jfwd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_data)
	);

	jfwd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_not_empty     (q_not_empty),
		.q_data          (pop_data),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.motor_pins      (motor_pins),
		.vertical_axis   (vertical_axis),
		.horizontal_axis (horizontal_axis),
		.axes_updated    (axes_updated)
	);

endmodule

// ===== verif/tb_joystick_frame_to_wheel_drive.sv =====
// Self-checking testbench for the joystick frame to wheel drive block.
module tb_joystick_frame_to_wheel_drive;
	import jfwd_pkg::*;

	typedef struct packed {
		logic [7:0] motor_pins;
		logic [7:0] vertical_axis;
		logic [7:0] horizontal_axis;
		logic       axes_updated;
	} drive_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		drive_t     want;
	} directed_row_t;

	localparam drive_t NO_DRIVE        = '0;
	localparam int     DIRECTED_ROWS   = 25;
	localparam int     PHASES          = 8;
	localparam int     BYTES_PER_PHASE = 138;
	localparam int     HOLD_CYCLES     = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        rx_valid  = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte   = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  motor_pins;
	logic [7:0]  vertical_axis;
	logic [7:0]  horizontal_axis;
	logic        axes_updated;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = 4'd0;
	logic [31:0] pwdata    = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state and its copy of the thresholds
	logic       fr_open         = 1'b0;
	logic       fr_horz         = 1'b0;
	logic [7:0] acc_vert        = 8'd0;
	logic [7:0] acc_horz        = 8'd0;
	logic [7:0] axis_vert       = AXIS_IDLE;
	logic [7:0] axis_horz       = AXIS_IDLE;
	logic [7:0] thr_corner_max  = RST_CORNER_MAX;
	logic [7:0] thr_middle_low  = RST_MIDDLE_LOW;
	logic [7:0] thr_middle_high = RST_MIDDLE_HIGH;
	logic [7:0] thr_corner_min  = RST_CORNER_MIN;

	drive_t drive_expected[$];
	int     fail_count    = 0;
	int     sent_count    = 0;
	int     send_idle_pct = 0;
	int     stall_pct     = 0;
	logic   row_typed     = 1'b0;
	drive_t row_want      = NO_DRIVE;
	logic   hold_kick     = 1'b0;
	logic   hold_seen     = 1'b0;
	int     hold_left     = 0;

	directed_row_t directed [DIRECTED_ROWS] = '{
		'{CHAR_A,  1'b1, '{PINS_LETTER_A, AXIS_IDLE, AXIS_IDLE, 1'b0}},
		'{CHAR_B,  1'b1, '{PINS_LETTER_B, AXIS_IDLE, AXIS_IDLE, 1'b0}},
		'{CHAR_C,  1'b1, '{PINS_LETTER_C, AXIS_IDLE, AXIS_IDLE, 1'b0}},
		'{CHAR_D,  1'b1, '{PINS_LETTER_D, AXIS_IDLE, AXIS_IDLE, 1'b0}},
		'{8'h00,   1'b1, '{PINS_STOP, AXIS_IDLE, AXIS_IDLE, 1'b0}},
		'{8'hFF,   1'b1, '{PINS_STOP, AXIS_IDLE, AXIS_IDLE, 1'b0}},
		'{CHAR_W,  1'b1, '{PINS_STOP, AXIS_IDLE, AXIS_IDLE, 1'b0}},
		// empty fields commit both axes as zero
		'{CHAR_CR, 1'b1, '{PINS_UP_LEFT, AXIS_MIN, AXIS_MIN, 1'b1}},
		// a zone wins over a letter
		'{CHAR_A,  1'b1, '{PINS_UP_LEFT, AXIS_MIN, AXIS_MIN, 1'b0}},
		'{CHAR_W,  1'b0, NO_DRIVE},
		'{8'h32,   1'b0, NO_DRIVE},
		'{8'h35,   1'b0, NO_DRIVE},
		'{8'h35,   1'b0, NO_DRIVE},
		'{8'h39,   1'b0, NO_DRIVE},
		'{CHAR_P,  1'b0, NO_DRIVE},
		'{CHAR_S,  1'b0, NO_DRIVE},
		'{CHAR_W,  1'b0, NO_DRIVE},
		'{CHAR_B,  1'b0, NO_DRIVE},
		'{CHAR_CR, 1'b0, NO_DRIVE},
		'{CHAR_W,  1'b0, NO_DRIVE},
		'{8'h39,   1'b0, NO_DRIVE},
		'{8'h39,   1'b0, NO_DRIVE},
		'{8'h39,   1'b0, NO_DRIVE},
		'{CHAR_CR, 1'b0, NO_DRIVE},
		'{CHAR_D,  1'b0, NO_DRIVE}
	};

	joystick_frame_to_wheel_drive u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_valid        (rx_valid),
		.rx_ready        (rx_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.motor_pins      (motor_pins),
		.vertical_axis   (vertical_axis),
		.horizontal_axis (horizontal_axis),
		.axes_updated    (axes_updated),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("mismatch: %s", msg);
	endfunction

	function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [7:0] b);
		int unsigned sum;
		sum = int'(acc) * 10 + int'(b[3:0]);
		return (sum > 255) ? AXIS_MAX : sum[7:0];
	endfunction

	function automatic logic in_middle(input logic [7:0] a);
		return a >= thr_middle_low && a <= thr_middle_high;
	endfunction

	function automatic logic [7:0] zone_pins(input logic [7:0] v, input logic [7:0] h,
			input logic letter_ok, input logic [7:0] b);
		if (v <= thr_corner_max && h <= thr_corner_max) return PINS_UP_LEFT;
		if (v == AXIS_MIN && in_middle(h)) return PINS_UP;
		if (v <= thr_corner_max && h >= thr_corner_min) return PINS_UP_RIGHT;
		if (in_middle(v) && h == AXIS_MAX) return PINS_RIGHT;
		if (v >= thr_corner_min && h >= thr_corner_min) return PINS_DOWN_RIGHT;
		if (v == AXIS_MAX && in_middle(h)) return PINS_DOWN;
		if (v >= thr_corner_min && h <= thr_corner_max) return PINS_DOWN_LEFT;
		if (in_middle(v) && h == AXIS_MIN) return PINS_LEFT;
		if (letter_ok) begin
			case (b)
				CHAR_A: return PINS_LETTER_A;
				CHAR_B: return PINS_LETTER_B;
				CHAR_C: return PINS_LETTER_C;
				CHAR_D: return PINS_LETTER_D;
				default: ;
			endcase
		end
		return PINS_STOP;
	endfunction

	// Advance the frame parser by one byte and give the drive it produces
	function automatic drive_t predict_drive(input logic [7:0] b);
		drive_t r;
		logic   letter_ok;
		logic   committed;
		letter_ok = 1'b0;
		committed = 1'b0;
		if (!fr_open) begin
			if (b == CHAR_W) begin
				fr_open = 1'b1;
				fr_horz = 1'b0;
				acc_vert = 8'd0;
				acc_horz = 8'd0;
			end else begin
				letter_ok = 1'b1;
			end
		end else if (b == CHAR_CR) begin
			axis_vert = acc_vert;
			axis_horz = acc_horz;
			acc_vert = 8'd0;
			acc_horz = 8'd0;
			fr_open = 1'b0;
			fr_horz = 1'b0;
			committed = 1'b1;
		end else if (b == CHAR_P || b == CHAR_S) begin
			fr_horz = 1'b1;
		end else if (fr_horz) begin
			acc_horz = add_digit(acc_horz, b);
		end else begin
			acc_vert = add_digit(acc_vert, b);
		end
		r.motor_pins = zone_pins(axis_vert, axis_horz, letter_ok, b);
		r.vertical_axis = axis_vert;
		r.horizontal_axis = axis_horz;
		r.axes_updated = committed;
		return r;
	endfunction

	// Check results first, then log the request taken at the same edge
	always @(posedge clk) begin : drive_monitor
		drive_t got;
		drive_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{motor_pins, vertical_axis, horizontal_axis, axes_updated};
				if (drive_expected.size() == 0) begin
					report_fail($sformatf("unexpected result pins %h v %0d h %0d upd %b",
						got.motor_pins, got.vertical_axis, got.horizontal_axis,
						got.axes_updated));
				end else begin
					want = drive_expected.pop_front();
					if (got.motor_pins !== want.motor_pins ||
							got.vertical_axis !== want.vertical_axis ||
							got.horizontal_axis !== want.horizontal_axis ||
							got.axes_updated !== want.axes_updated) begin
						report_fail($sformatf(
							"pins %h/%h v %0d/%0d h %0d/%0d upd %b/%b (expected/actual)",
							want.motor_pins, got.motor_pins,
							want.vertical_axis, got.vertical_axis,
							want.horizontal_axis, got.horizontal_axis,
							want.axes_updated, got.axes_updated));
					end
				end
			end
			if (rx_valid && rx_ready) begin
				want = predict_drive(rx_byte);
				if (row_typed) want = row_want;
				drive_expected.push_back(want);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when kicked
	always @(negedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen = hold_kick;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_byte(input logic [7:0] b, input logic typed, input drive_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		row_typed <= typed;
		row_want <= want;
		// hold the request until it is taken
		do @(posedge clk); while (!rx_ready);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		offer_byte(b, 1'b0, NO_DRIVE);
	endtask

	function automatic logic [7:0] digit_byte(input int d);
		logic [7:0] b;
		b = {($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'h3, 4'(d)};
		if (b == CHAR_P || b == CHAR_S) b = {4'h3, 4'(d)};
		return b;
	endfunction

	task automatic emit_number(input int val);
		logic keep_zeros;
		keep_zeros = ($urandom_range(3) == 0);
		if (val >= 100 || keep_zeros) send_byte(digit_byte((val / 100) % 10));
		if (val >= 10 || keep_zeros) send_byte(digit_byte((val / 10) % 10));
		send_byte(digit_byte(val % 10));
	endtask

	function automatic int rand_axis();
		int t;
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			2: return $urandom_range(999, 256);
			3: begin
				case ($urandom_range(3))
					0: t = thr_corner_max;
					1: t = thr_middle_low;
					2: t = thr_middle_high;
					default: t = thr_corner_min;
				endcase
				t = t + $urandom_range(2) - 1;
				if (t < 0) t = 0;
				if (t > 255) t = 255;
				return t;
			end
			default: return $urandom_range(255);
		endcase
	endfunction

	task automatic send_frame();
		int kind;
		kind = $urandom_range(99);
		send_byte(CHAR_W);
		if (kind >= 5) emit_number(rand_axis());
		// drop the separator now and then
		if (kind < 5 || kind >= 10) begin
			send_byte($urandom_range(1) ? CHAR_P : CHAR_S);
			if ($urandom_range(9) == 0) send_byte($urandom_range(1) ? CHAR_P : CHAR_S);
		end
		if (kind < 10 || kind >= 15) emit_number(rand_axis());
		if (kind >= 95) send_byte(8'($urandom_range(255)));
		send_byte(CHAR_CR);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(3, 1)) begin
			if ($urandom_range(1)) send_byte(8'(CHAR_A + $urandom_range(3)));
			else send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic wait_drain();
		while (drive_expected.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write then read back; called at a falling edge with the block idle
	task automatic set_threshold(input reg_idx_t idx, input logic [7:0] val);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_CORNER_MAX:  thr_corner_max = val;
			REG_MIDDLE_LOW:  thr_middle_low = val;
			REG_MIDDLE_HIGH: thr_middle_high = val;
			REG_CORNER_MIN:  thr_corner_min = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (rd !== {24'd0, val})
			report_fail($sformatf("register %0d read %h, expected %h", idx, rd, val));
	endtask

	initial begin : stimulus
		int         phase;
		int         row;
		int         i;
		int         phase_start;
		logic       hold_done;
		logic       pause_done;
		logic [7:0] th [4];
		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++)
			offer_byte(directed[row].rx, directed[row].typed, directed[row].want);
		rx_valid <= 1'b0;
		wait_drain();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 87; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 87; end
				default: begin send_idle_pct = 33; stall_pct = 33; end
			endcase
			case (phase)
				0: th = '{RST_CORNER_MAX, RST_MIDDLE_LOW, RST_MIDDLE_HIGH, RST_CORNER_MIN};
				1: th = '{8'd0, 8'd0, 8'd0, 8'd0};
				2: th = '{8'd255, 8'd255, 8'd255, 8'd255};
				// thresholds out of order
				3: th = '{8'd200, 8'd150, 8'd50, 8'd10};
				4: th = '{8'd0, 8'd0, 8'd255, 8'd255};
				default: for (i = 0; i < 4; i++) th[i] = 8'($urandom_range(255));
			endcase
			for (i = 0; i < 4; i++) set_threshold(reg_idx_t'(i), th[i]);

			phase_start = sent_count;
			while (sent_count - phase_start < BYTES_PER_PHASE) begin
				// stall the output for a long stretch while requests keep coming
				if (phase == 0 && !hold_done && sent_count - phase_start >= 40) begin
					hold_kick <= ~hold_kick;
					hold_done = 1'b1;
				end
				if (phase == 1 && !pause_done && sent_count - phase_start >= 60) begin
					rx_valid <= 1'b0;
					wait_drain();
					pause_done = 1'b1;
				end
				if ($urandom_range(4) == 0) send_noise();
				else send_frame();
			end
			rx_valid <= 1'b0;
			wait_drain();
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0 && drive_expected.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
